[rtl/expadsr_pkg.sv]
package expadsr_pkg;

   // Envelope stages.
   typedef enum logic [2:0] {
      STG_OFF     = 3'd0,
      STG_ATTACK  = 3'd1,
      STG_DECAY   = 3'd2,
      STG_SUSTAIN = 3'd3,
      STG_RELEASE = 3'd4
   } stage_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_LOG_INIT,
      S_LOG_NORM,
      S_LOG_SQ,
      S_LOG_DONE,
      S_PROD,
      S_DIV,
      S_RATE,
      S_MUL,
      S_FINISH
   } seq_state_type;

   // Which part of the tick the dispatcher handles next.
   typedef enum logic [1:0] {
      PH_START,
      PH_REL,
      PH_ADV,
      PH_MUL
   } phase_type;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_ATTACK_LEN  = 3'd0;
   localparam logic [2:0] REG_DECAY_LEN   = 3'd1;
   localparam logic [2:0] REG_SUSTAIN     = 3'd2;
   localparam logic [2:0] REG_RELEASE_LEN = 3'd3;
   localparam logic [2:0] REG_FLOOR       = 3'd4;
   localparam logic [2:0] REG_ATT_START   = 3'd5;

   localparam logic [23:0] ATTACK_LEN_RST  = 24'd480;
   localparam logic [23:0] DECAY_LEN_RST   = 24'd4800;
   localparam logic [15:0] SUSTAIN_RST     = 16'd16384;
   localparam logic [23:0] RELEASE_LEN_RST = 24'd9600;
   localparam logic [15:0] FLOOR_RST       = 16'd33;
   localparam logic [15:0] ATT_START_RST   = 16'd33;

   localparam int LENGTH_BITS_DEF     = 24;
   localparam int LEVEL_FRAC_BITS_DEF = 31;

   localparam logic [31:0] RATE_ONE = 32'h1000_0000;
   localparam int          MAG_W    = 30;
   localparam int          PROD_W   = 60;
   localparam int          LOG_FRAC = 24;
   localparam logic [29:0] LN2_Q30  = 30'd744261118;

endpackage

[rtl/exponential_adsr_envelope.sv]
// Channel  Direction  Handshake             Payload
// req      in         req_tvalid/tready     tdata[0] start_req, tdata[1] released
// rsp      out        rsp_tvalid/tready     tdata[15:0] level, tdata[16] active
// csr      in         APB, pready tied high six registers at byte address 4*i
//
// A tick in off or sustain skips the multiply step that a tick in a timed stage takes.
// A stage entry with a nonzero length adds a rate computation: two logs, a product, a
// restoring divide and a rate step. At most two entries per tick compute a rate.
// Reset is synchronous and returns the stage to off and the registers to their defaults.
// A stalled rsp side holds the sequencer in its final state; req_tready is high when idle.
module exponential_adsr_envelope #(
   parameter int LENGTH_BITS     = expadsr_pkg::LENGTH_BITS_DEF,
   parameter int LEVEL_FRAC_BITS = expadsr_pkg::LEVEL_FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] start_req, [1] released, rest zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] level, [16] active, rest zero
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import expadsr_pkg::*;

   localparam int LW = LEVEL_FRAC_BITS + 1;
   localparam logic [LW-1:0] LEVEL_ONE = LW'(1) << LEVEL_FRAC_BITS;

   // Widens a Q1.15 register to the level format, clamped to 1 .. 1.0.
   function automatic logic [LW-1:0] widen(input logic [15:0] v);
      logic [15:0] c;
      c = v;
      if (c > 16'd32768) c = 16'd32768;
      if (c == 16'd0) c = 16'd1;
      return LW'(c) << (LEVEL_FRAC_BITS - 15);
   endfunction

   function automatic logic [LENGTH_BITS-1:0] to_len(input logic [23:0] v);
      logic [31:0] t;
      t = 32'(v);
      return t[LENGTH_BITS-1:0];
   endfunction

   // Configuration registers.
   logic [23:0] attack_len_ff, attack_len_in;
   logic [23:0] decay_len_ff, decay_len_in;
   logic [15:0] sustain_ff, sustain_in;
   logic [23:0] release_len_ff, release_len_in;
   logic [15:0] floor_ff, floor_in;
   logic [15:0] att_start_ff, att_start_in;

   // Envelope state.
   stage_type             stage_ff, stage_in;
   logic [LW-1:0]         level_ff, level_in;
   logic [31:0]           rate_ff, rate_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;

   // Sequencer and tick.
   seq_state_type state_ff, state_in;
   phase_type     phase_ff, phase_in;
   logic          start_ff, start_in;
   logic          rel_ff, rel_in;
   logic          active_ff, active_in;

   // Rate computation datapath.
   logic [31:0]            calc_start_ff, calc_start_in;
   logic [31:0]            calc_end_ff, calc_end_in;
   logic                   lg_sel_ff, lg_sel_in;
   logic [31:0]            lg_m_ff, lg_m_in;
   logic [4:0]             lg_p_ff, lg_p_in;
   logic [LOG_FRAC-1:0]    lg_frac_ff, lg_frac_in;
   logic signed [31:0]     log_end_ff, log_end_in;
   logic [MAG_W-1:0]       mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   logic [PROD_W-1:0]      dq_ff, dq_in;
   logic [LENGTH_BITS-1:0] rem_ff, rem_in;
   logic [5:0]             cnt_ff, cnt_in;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_level_ff, rsp_level_in;
   logic        rsp_active_ff, rsp_active_in;

   logic cfg_write;
   assign cfg_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_paddr[4:2])
         REG_ATTACK_LEN:  csr_prdata = 32'(attack_len_ff);
         REG_DECAY_LEN:   csr_prdata = 32'(decay_len_ff);
         REG_SUSTAIN:     csr_prdata = 32'(sustain_ff);
         REG_RELEASE_LEN: csr_prdata = 32'(release_len_ff);
         REG_FLOOR:       csr_prdata = 32'(floor_ff);
         REG_ATT_START:   csr_prdata = 32'(att_start_ff);
         default:         csr_prdata = 32'd0;
      endcase
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_active_ff, rsp_level_ff};

   always_comb begin
      logic                   enter_do;
      stage_type              enter_tgt;
      logic [LW-1:0]          hold;
      logic [LW-1:0]          flv;
      logic                   timed;
      logic [63:0]            sq;
      logic signed [7:0]      lg_exp;
      logic signed [31:0]     lg_val;
      logic signed [31:0]     dlog;
      logic [31:0]            dmag;
      logic [LENGTH_BITS:0]   sh;
      logic [LENGTH_BITS:0]   diff;
      logic [33:0]            qv;
      logic [34:0]            qsum;
      logic [LW+31:0]         mprod;
      logic [LW+3:0]          mshift;

      attack_len_in  = attack_len_ff;
      decay_len_in   = decay_len_ff;
      sustain_in     = sustain_ff;
      release_len_in = release_len_ff;
      floor_in       = floor_ff;
      att_start_in   = att_start_ff;
      stage_in       = stage_ff;
      level_in       = level_ff;
      rate_in        = rate_ff;
      count_in       = count_ff;
      len_in         = len_ff;
      state_in       = state_ff;
      phase_in       = phase_ff;
      start_in       = start_ff;
      rel_in         = rel_ff;
      active_in      = active_ff;
      calc_start_in  = calc_start_ff;
      calc_end_in    = calc_end_ff;
      lg_sel_in      = lg_sel_ff;
      lg_m_in        = lg_m_ff;
      lg_p_in        = lg_p_ff;
      lg_frac_in     = lg_frac_ff;
      log_end_in     = log_end_ff;
      mag_in         = mag_ff;
      neg_in         = neg_ff;
      dq_in          = dq_ff;
      rem_in         = rem_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_level_in   = rsp_level_ff;
      rsp_active_in  = rsp_active_ff;

      enter_do  = 1'b0;
      enter_tgt = STG_OFF;
      hold      = widen(sustain_ff);
      flv       = widen(floor_ff);
      if (flv > hold) hold = flv;
      timed = (stage_ff == STG_ATTACK) || (stage_ff == STG_DECAY) ||
              (stage_ff == STG_RELEASE);
      sq     = 64'(lg_m_ff) * 64'(lg_m_ff);
      lg_exp = $signed({3'd0, lg_p_ff}) - 8'(LEVEL_FRAC_BITS);
      lg_val = {lg_exp, lg_frac_ff};
      dlog   = log_end_ff - lg_val;
      dmag   = dlog[31] ? (32'd0 - dlog) : dlog;
      sh     = {rem_ff, dq_ff[PROD_W-1]};
      diff   = sh - {1'b0, len_ff};
      qv     = dq_ff[PROD_W-1:26];
      qsum   = 35'(qv) + 35'(RATE_ONE);
      mprod  = (LW+32)'(level_ff) * (LW+32)'(rate_ff);
      mshift = mprod[LW+31:28];

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      if (cfg_write) begin
         unique case (csr_paddr[4:2])
            REG_ATTACK_LEN:  attack_len_in  = csr_pwdata[23:0];
            REG_DECAY_LEN:   decay_len_in   = csr_pwdata[23:0];
            REG_SUSTAIN:     sustain_in     = csr_pwdata[15:0];
            REG_RELEASE_LEN: release_len_in = csr_pwdata[23:0];
            REG_FLOOR:       floor_in       = csr_pwdata[15:0];
            REG_ATT_START:   att_start_in   = csr_pwdata[15:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               start_in = req_tdata[0];
               rel_in   = req_tdata[1];
               phase_in = PH_START;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (phase_ff)
               PH_START: begin
                  phase_in = PH_REL;
                  if (start_ff) begin
                     enter_do  = 1'b1;
                     enter_tgt = STG_ATTACK;
                  end
               end
               PH_REL: begin
                  phase_in  = PH_ADV;
                  active_in = (stage_ff != STG_OFF);
                  if (rel_ff && (stage_ff == STG_ATTACK || stage_ff == STG_DECAY ||
                                 stage_ff == STG_SUSTAIN)) begin
                     enter_do  = 1'b1;
                     enter_tgt = STG_RELEASE;
                  end
               end
               PH_ADV: begin
                  if (timed) begin
                     phase_in = PH_MUL;
                     if (count_ff >= len_ff) begin
                        enter_do = 1'b1;
                        unique case (stage_ff)
                           STG_ATTACK: enter_tgt = STG_DECAY;
                           STG_DECAY:  enter_tgt = STG_SUSTAIN;
                           default:    enter_tgt = STG_OFF;
                        endcase
                     end
                  end else begin
                     state_in = S_FINISH;
                  end
               end
               PH_MUL: state_in = S_MUL;
               default: state_in = S_FINISH;
            endcase

            // Stage entry: loads the stage registers and starts a rate
            // computation when the stage is timed and its length is nonzero.
            if (enter_do) begin
               stage_in  = enter_tgt;
               count_in  = '0;
               rate_in   = RATE_ONE;
               lg_sel_in = 1'b0;
               unique case (enter_tgt)
                  STG_ATTACK: begin
                     len_in        = to_len(attack_len_ff);
                     level_in      = widen(att_start_ff);
                     calc_start_in = 32'(widen(att_start_ff));
                     calc_end_in   = 32'(LEVEL_ONE);
                  end
                  STG_DECAY: begin
                     len_in        = to_len(decay_len_ff);
                     level_in      = LEVEL_ONE;
                     calc_start_in = 32'(LEVEL_ONE);
                     calc_end_in   = 32'(hold);
                  end
                  STG_SUSTAIN: begin
                     len_in   = '0;
                     level_in = hold;
                  end
                  STG_RELEASE: begin
                     len_in        = to_len(release_len_ff);
                     calc_start_in = 32'(level_ff);
                     calc_end_in   = 32'(flv);
                  end
                  default: begin
                     len_in   = '0;
                     level_in = '0;
                  end
               endcase
               if ((enter_tgt == STG_ATTACK || enter_tgt == STG_DECAY ||
                    enter_tgt == STG_RELEASE) && (len_in != '0)) begin
                  state_in = S_LOG_INIT;
               end
            end
         end
         S_LOG_INIT: begin
            lg_m_in = lg_sel_ff ? calc_start_ff : calc_end_ff;
            if (lg_m_in == 32'd0) lg_m_in = 32'd1;
            lg_p_in  = 5'd31;
            state_in = S_LOG_NORM;
         end
         S_LOG_NORM: begin
            // One bit of normalizing shift per cycle.
            if (lg_m_ff[31]) begin
               cnt_in     = '0;
               lg_frac_in = '0;
               state_in   = S_LOG_SQ;
            end else begin
               lg_m_in = {lg_m_ff[30:0], 1'b0};
               lg_p_in = lg_p_ff - 5'd1;
            end
         end
         S_LOG_SQ: begin
            // One fraction bit per squaring.
            if (sq[63]) begin
               lg_m_in    = sq[63:32];
               lg_frac_in = {lg_frac_ff[LOG_FRAC-2:0], 1'b1};
            end else begin
               lg_m_in    = sq[62:31];
               lg_frac_in = {lg_frac_ff[LOG_FRAC-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(LOG_FRAC - 1)) state_in = S_LOG_DONE;
         end
         S_LOG_DONE: begin
            if (!lg_sel_ff) begin
               log_end_in = lg_val;
               lg_sel_in  = 1'b1;
               state_in   = S_LOG_INIT;
            end else begin
               neg_in   = dlog[31];
               mag_in   = dmag[MAG_W-1:0];
               state_in = S_PROD;
            end
         end
         S_PROD: begin
            dq_in    = PROD_W'(mag_ff) * PROD_W'(LN2_Q30);
            rem_in   = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            // Restoring division, one quotient bit per cycle.
            if (!diff[LENGTH_BITS]) begin
               rem_in = diff[LENGTH_BITS-1:0];
               dq_in  = {dq_ff[PROD_W-2:0], 1'b1};
            end else begin
               rem_in = sh[LENGTH_BITS-1:0];
               dq_in  = {dq_ff[PROD_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(PROD_W - 1)) state_in = S_RATE;
         end
         S_RATE: begin
            if (neg_ff) begin
               rate_in = (qv >= 34'(RATE_ONE)) ? 32'd0 : (RATE_ONE - qv[31:0]);
            end else begin
               rate_in = qsum[34:32] != 3'd0 ? 32'hFFFF_FFFF : qsum[31:0];
            end
            state_in = S_DISPATCH;
         end
         S_MUL: begin
            level_in = (mshift > (LW+4)'(LEVEL_ONE)) ? LEVEL_ONE : mshift[LW-1:0];
            count_in = count_ff + LENGTH_BITS'(1);
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_level_in  = level_ff[LEVEL_FRAC_BITS-15 +: 16];
               rsp_active_in = active_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_len_ff  <= ATTACK_LEN_RST;
         decay_len_ff   <= DECAY_LEN_RST;
         sustain_ff     <= SUSTAIN_RST;
         release_len_ff <= RELEASE_LEN_RST;
         floor_ff       <= FLOOR_RST;
         att_start_ff   <= ATT_START_RST;
         stage_ff       <= STG_OFF;
         level_ff       <= '0;
         rate_ff        <= RATE_ONE;
         count_ff       <= '0;
         len_ff         <= '0;
         state_ff       <= S_IDLE;
         phase_ff       <= PH_START;
         rsp_valid_ff   <= 1'b0;
      end else begin
         attack_len_ff  <= attack_len_in;
         decay_len_ff   <= decay_len_in;
         sustain_ff     <= sustain_in;
         release_len_ff <= release_len_in;
         floor_ff       <= floor_in;
         att_start_ff   <= att_start_in;
         stage_ff       <= stage_in;
         level_ff       <= level_in;
         rate_ff        <= rate_in;
         count_ff       <= count_in;
         len_ff         <= len_in;
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff      <= start_in;
      rel_ff        <= rel_in;
      active_ff     <= active_in;
      calc_start_ff <= calc_start_in;
      calc_end_ff   <= calc_end_in;
      lg_sel_ff     <= lg_sel_in;
      lg_m_ff       <= lg_m_in;
      lg_p_ff       <= lg_p_in;
      lg_frac_ff    <= lg_frac_in;
      log_end_ff    <= log_end_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      dq_ff         <= dq_in;
      rem_ff        <= rem_in;
      cnt_ff        <= cnt_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_active_ff <= rsp_active_in;
   end

endmodule
